FILE: design/dbs_pkg.sv
// dbs_pkg: sizes, codes and shared types of the deque/bag store.
// No dependencies; every other design file imports this package.
package dbs_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int MODE_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	localparam cnt_t FULL_CNT = CNT_W'(DEPTH);
	localparam cnt_t LAST_POS = CNT_W'(DEPTH - 1);

	localparam logic [MODE_W-1:0] MODE_ADD_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CONTAINS  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REM_VALUE = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		OP_ADD_FRONT,
		OP_ADD_BACK,
		OP_REM_FRONT,
		OP_REM_BACK,
		OP_FIND,
		OP_DELETE,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t   op;
		data_t value;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic                      found;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] back_value;
		logic                      is_empty;
		logic [COUNT_W-1:0]        entry_count;
	} res_t;

endpackage

FILE: design/dbs_if.sv
// dbs_req_if / dbs_rsp_if: valid/ready channels of the deque/bag store.
// Depends on dbs_pkg for field widths.
interface dbs_req_if import dbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface dbs_rsp_if import dbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic                      found;
	logic signed [VALUE_W-1:0] front_value;
	logic signed [VALUE_W-1:0] back_value;
	logic                      is_empty;
	logic [COUNT_W-1:0]        entry_count;

	modport source (output valid, output status, output found, output front_value,
		output back_value, output is_empty, output entry_count, input ready);
	modport sink (input valid, input status, input found, input front_value,
		input back_value, input is_empty, input entry_count, output ready);
endinterface

FILE: design/dbs_front.sv
// dbs_front: takes request beats and decodes the mode into a command.
// Depends on dbs_pkg and dbs_req_if.
module dbs_front import dbs_pkg::*; (
	dbs_req_if.sink     req,
	output cmd_t        cmd,
	output logic        cmd_vld,
	input  logic        cmd_rdy
);

	op_t op;

	always_comb begin
		unique case (req.mode)
			MODE_ADD_FRONT: op = OP_ADD_FRONT;
			MODE_ADD_BACK:  op = OP_ADD_BACK;
			MODE_REM_FRONT: op = OP_REM_FRONT;
			MODE_REM_BACK:  op = OP_REM_BACK;
			MODE_CONTAINS:  op = OP_FIND;
			MODE_REM_VALUE: op = OP_DELETE;
			default:        op = OP_NOP;
		endcase
	end

	assign cmd.op    = op;
	assign cmd.value = DATA_WIDTH'(req.value);
	assign cmd_vld   = req.valid;
	assign req.ready = cmd_rdy;

endmodule

FILE: design/dbs_cmd_fifo.sv
// dbs_cmd_fifo: short command queue between decode and execution.
// Depends on dbs_pkg.
module dbs_cmd_fifo import dbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_cmd,
	input  logic push_vld,
	output logic push_rdy,
	output cmd_t pop_cmd,
	output logic pop_vld,
	input  logic pop_rdy
);

	cmd_t                  buf_q [CMDQ_DEPTH];
	logic [CMDQ_IDX_W-1:0] wr_ptr_q;
	logic [CMDQ_IDX_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  push;
	logic                  pop;

	assign push_rdy = cnt_q != CMDQ_CNT_W'(CMDQ_DEPTH);
	assign pop_vld  = cnt_q != '0;
	assign pop_cmd  = buf_q[rd_ptr_q];
	assign push     = push_vld && push_rdy;
	assign pop      = pop_vld && pop_rdy;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/dbs_back.sv
// dbs_back: executes commands on the ring of slots and holds the result beat.
// Depends on dbs_pkg; slot storage is a one-read one-write memory in here.
module dbs_back import dbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_vld,
	output logic cmd_rdy,
	output res_t res,
	output logic res_vld,
	input  logic res_rdy
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_SHIFT = 6'b000100,
		ST_REF_F = 6'b001000,
		ST_REF_B = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	function automatic idx_t ring_pos(input idx_t h, input cnt_t k);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(h) + (CNT_W + 1)'(k);
		if (s >= (CNT_W + 1)'(DEPTH)) begin
			s = s - (CNT_W + 1)'(DEPTH);
		end
		return IDX_W'(s);
	endfunction

	data_t  mem [DEPTH];
	data_t  rdata_q;

	state_t              state_q;
	idx_t                head_q;
	cnt_t                occ_q;
	cnt_t                idx_q;
	cnt_t                pend_idx_q;
	logic                pend_vld_q;
	data_t               val_q;
	logic                del_q;
	logic [STATUS_W-1:0] status_q;
	logic                found_q;
	data_t               front_q;
	res_t                res_q;
	logic                res_vld_q;

	logic  rd_en;
	idx_t  rd_addr;
	logic  wr_en;
	idx_t  wr_addr;
	data_t wr_data;
	logic  full;
	logic  empty;
	logic  more;
	logic  hit;
	logic  load;

	assign full    = occ_q == FULL_CNT;
	assign empty   = occ_q == '0;
	assign more    = idx_q < occ_q;
	assign hit     = pend_vld_q && (rdata_q == val_q);
	assign load    = (state_q == ST_DONE) && (!res_vld_q || res_rdy);
	assign cmd_rdy = state_q == ST_IDLE;
	assign res     = res_q;
	assign res_vld = res_vld_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = cmd.value;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_vld && !full) begin
					if (cmd.op == OP_ADD_FRONT) begin
						wr_en   = 1'b1;
						wr_addr = ring_pos(head_q, LAST_POS);
					end else if (cmd.op == OP_ADD_BACK) begin
						wr_en   = 1'b1;
						wr_addr = ring_pos(head_q, occ_q);
					end
				end
			end
			ST_SCAN, ST_SHIFT: begin
				rd_en   = more;
				rd_addr = ring_pos(head_q, idx_q);
				if (state_q == ST_SHIFT && pend_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = ring_pos(head_q, pend_idx_q);
					wr_data = rdata_q;
				end
			end
			ST_REF_F: begin
				rd_en   = 1'b1;
				rd_addr = head_q;
			end
			ST_REF_B: begin
				rd_en   = 1'b1;
				rd_addr = ring_pos(head_q, occ_q - 1'b1);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			occ_q      <= '0;
			idx_q      <= '0;
			pend_idx_q <= '0;
			pend_vld_q <= 1'b0;
			val_q      <= '0;
			del_q      <= 1'b0;
			status_q   <= STAT_OK;
			found_q    <= 1'b0;
			front_q    <= '0;
			res_q      <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= load || (res_vld_q && !res_rdy);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_vld) begin
						status_q   <= STAT_OK;
						found_q    <= 1'b0;
						val_q      <= cmd.value;
						del_q      <= cmd.op == OP_DELETE;
						idx_q      <= '0;
						pend_vld_q <= 1'b0;
						state_q    <= ST_REF_F;
						case (cmd.op)
							OP_ADD_FRONT: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									head_q <= ring_pos(head_q, LAST_POS);
									occ_q  <= occ_q + 1'b1;
								end
							end
							OP_ADD_BACK: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									occ_q <= occ_q + 1'b1;
								end
							end
							OP_REM_FRONT: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									head_q <= ring_pos(head_q, CNT_W'(1));
									occ_q  <= occ_q - 1'b1;
								end
							end
							OP_REM_BACK: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									occ_q <= occ_q - 1'b1;
								end
							end
							OP_FIND, OP_DELETE: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (more) begin
						idx_q      <= idx_q + 1'b1;
						pend_idx_q <= idx_q;
						pend_vld_q <= 1'b1;
					end else begin
						pend_vld_q <= 1'b0;
					end
					if (hit) begin
						found_q    <= 1'b1;
						pend_vld_q <= 1'b0;
						idx_q      <= pend_idx_q + 1'b1;
						state_q    <= del_q ? ST_SHIFT : ST_REF_F;
					end else if (pend_vld_q && pend_idx_q == occ_q - 1'b1) begin
						state_q <= ST_REF_F;
					end
				end
				ST_SHIFT: begin
					if (more) begin
						idx_q      <= idx_q + 1'b1;
						pend_idx_q <= idx_q - 1'b1;
						pend_vld_q <= 1'b1;
					end else begin
						pend_vld_q <= 1'b0;
						if (!pend_vld_q) begin
							occ_q   <= occ_q - 1'b1;
							state_q <= ST_REF_F;
						end
					end
				end
				ST_REF_F: begin
					state_q <= ST_REF_B;
				end
				ST_REF_B: begin
					front_q <= rdata_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load) begin
						res_q.status      <= status_q;
						res_q.found       <= found_q;
						res_q.front_value <= empty ? '0 : VALUE_W'(front_q);
						res_q.back_value  <= empty ? '0 : VALUE_W'(rdata_q);
						res_q.is_empty    <= empty;
						res_q.entry_count <= COUNT_W'(occ_q);
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/deque_bag_store_unit.sv
// Deque/bag store of DEPTH signed words: one result beat for every request beat.
// Each request passes from queue pop through execution to result: adds, removes at
// either end and unused modes go straight to the front and back read-back; contains
// first scans the entries, and remove-value with a match also moves later entries up
// to close the gap. The slot memory (one read, one write per cycle) sets these steps:
// the scan and the gap close move one entry per cycle, then front and back are read
// back in turn.
// A two-beat command queue lets requests arrive while earlier ones execute, and the
// result register lets the next command start while a result waits to be taken.
// Depends on dbs_pkg, dbs_if, dbs_front, dbs_cmd_fifo and dbs_back.
module deque_bag_store_unit import dbs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	dbs_req_if.sink    req,
	dbs_rsp_if.source  rsp
);

	cmd_t dec_cmd;
	logic dec_vld;
	logic dec_rdy;
	cmd_t q_cmd;
	logic q_vld;
	logic q_rdy;
	res_t res;

	dbs_front u_front (
		.req     (req),
		.cmd     (dec_cmd),
		.cmd_vld (dec_vld),
		.cmd_rdy (dec_rdy)
	);

	dbs_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cmd (dec_cmd),
		.push_vld (dec_vld),
		.push_rdy (dec_rdy),
		.pop_cmd  (q_cmd),
		.pop_vld  (q_vld),
		.pop_rdy  (q_rdy)
	);

	dbs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (q_cmd),
		.cmd_vld (q_vld),
		.cmd_rdy (q_rdy),
		.res     (res),
		.res_vld (rsp.valid),
		.res_rdy (rsp.ready)
	);

	assign rsp.status      = res.status;
	assign rsp.found       = res.found;
	assign rsp.front_value = res.front_value;
	assign rsp.back_value  = res.back_value;
	assign rsp.is_empty    = res.is_empty;
	assign rsp.entry_count = res.entry_count;

endmodule

FILE: design/dbs_checker.sv
// dbs_checker: port-level assertions for deque_bag_store_unit, bound to the top.
// Depends on dbs_pkg and deque_bag_store_unit.
module dbs_checker import dbs_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic [STATUS_W-1:0]       status,
	input logic                      found,
	input logic signed [VALUE_W-1:0] front_value,
	input logic signed [VALUE_W-1:0] back_value,
	input logic                      is_empty,
	input logic [COUNT_W-1:0]        entry_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> (front_value == '0) && (back_value == '0))
		else $error("front/back not zero on empty store");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_FULL |-> entry_count == COUNT_W'(DEPTH) && !found)
		else $error("full status with store not full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= COUNT_W'(DEPTH)
			&& (status == STAT_OK || status == STAT_FULL || status == STAT_EMPTY))
		else $error("count or status out of range");

endmodule

bind deque_bag_store_unit dbs_checker u_dbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.found       (rsp.found),
	.front_value (rsp.front_value),
	.back_value  (rsp.back_value),
	.is_empty    (rsp.is_empty),
	.entry_count (rsp.entry_count)
);
